// File: rtl/core/qfo_pkg.sv
// Shared types and constants for the quaternion fractal orbit step core.
// Depends on nothing; imported by every module of the core.
`default_nettype none

package qfo_pkg;

    localparam int FRAC_BITS = 28;
    localparam int COMP_W    = 32;
    localparam int MAG_W     = 32;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COMP_W-1:0] comp_t;

    typedef struct packed {
        comp_t a;
        comp_t b;
        comp_t c;
        comp_t d;
    } quat_t;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_ITERATE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_JULIA_MODE    = 3'd0,
        REG_CONST_REAL    = 3'd1,
        REG_CONST_I       = 3'd2,
        REG_CONST_J       = 3'd3,
        REG_CONST_K       = 3'd4,
        REG_START_J       = 3'd5,
        REG_START_K       = 3'd6,
        REG_BAILOUT_LIMIT = 3'd7
    } reg_idx_t;

    localparam logic [MAG_W-1:0] BAILOUT_RESET = 32'h4000_0000;

    typedef struct packed {
        logic             julia_mode;
        comp_t            const_real;
        comp_t            const_i;
        comp_t            const_j;
        comp_t            const_k;
        comp_t            start_j;
        comp_t            start_k;
        logic [MAG_W-1:0] bailout_limit;
    } cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/qfo_cfg_regs.sv
// Configuration register file of the orbit step core.
// Depends on qfo_pkg for the register index codes and the cfg_t bundle.
`default_nettype none

module qfo_cfg_regs
    import qfo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 wr_en,
    input  wire logic [CFG_IDX_W-1:0] wr_index,
    input  wire logic [31:0]          wr_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_JULIA_MODE:    cfg_next.julia_mode    = wr_data[0];
                REG_CONST_REAL:    cfg_next.const_real    = wr_data;
                REG_CONST_I:       cfg_next.const_i       = wr_data;
                REG_CONST_J:       cfg_next.const_j       = wr_data;
                REG_CONST_K:       cfg_next.const_k       = wr_data;
                REG_START_J:       cfg_next.start_j       = wr_data;
                REG_START_K:       cfg_next.start_k       = wr_data;
                REG_BAILOUT_LIMIT: cfg_next.bailout_limit = wr_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{julia_mode: 1'b1, bailout_limit: BAILOUT_RESET, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: rtl/core/qfo_step_dp.sv
// Single-pass datapath: start loading, squared magnitude, bailout test and z*z+c.
// Depends on qfo_pkg for quat_t, cfg_t and the operation codes.
`default_nettype none

module qfo_step_dp
    import qfo_pkg::*;
(
    input  wire logic        operation,
    input  wire comp_t       pixel_re,
    input  wire comp_t       pixel_im,
    input  wire quat_t       z,
    input  wire comp_t       c0,
    input  wire comp_t       c1,
    input  wire cfg_t        cfg,
    output quat_t            z_next,
    output comp_t            c0_next,
    output comp_t            c1_next,
    output logic             escaped,
    output logic [MAG_W-1:0] magnitude
);

    localparam int SQ_W  = 2 * COMP_W - 1 - FRAC_BITS;
    localparam int SUM_W = SQ_W + 2;
    localparam int ACC_W = SUM_W + 1;

    function automatic comp_t sat_comp(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] max_v;
        logic signed [ACC_W-1:0] min_v;
        max_v = ACC_W'(32'sh7FFF_FFFF);
        min_v = -(ACC_W'(32'sh7FFF_FFFF)) - ACC_W'(1);
        if (v > max_v)
            sat_comp = comp_t'(max_v);
        else if (v < min_v)
            sat_comp = comp_t'(min_v);
        else
            sat_comp = comp_t'(v);
    endfunction

    logic signed [2*COMP_W-1:0] sq0, sq1, sq2, sq3;
    logic signed [2*COMP_W-1:0] pr1, pr2, pr3;
    logic [SQ_W-1:0]            s0, s1, s2, s3;
    logic [SUM_W-1:0]           mag_sum;
    logic signed [ACC_W-1:0]    re_acc, i_acc, j_acc, k_acc;
    logic                       over_limit;
    quat_t                      z_iter;

    always_comb
    begin
        sq0 = z.a * z.a;
        sq1 = z.b * z.b;
        sq2 = z.c * z.c;
        sq3 = z.d * z.d;
        pr1 = z.a * z.b;
        pr2 = z.a * z.c;
        pr3 = z.a * z.d;

        s0 = sq0[2*COMP_W-2:FRAC_BITS];
        s1 = sq1[2*COMP_W-2:FRAC_BITS];
        s2 = sq2[2*COMP_W-2:FRAC_BITS];
        s3 = sq3[2*COMP_W-2:FRAC_BITS];

        mag_sum = SUM_W'(s0) + SUM_W'(s1) + SUM_W'(s2) + SUM_W'(s3);
        over_limit = mag_sum > SUM_W'(cfg.bailout_limit);

        re_acc = $signed(ACC_W'(s0)) - $signed(ACC_W'(s1)) - $signed(ACC_W'(s2))
               - $signed(ACC_W'(s3)) + ACC_W'(c0);
        i_acc  = ACC_W'($signed(pr1[2*COMP_W-1:FRAC_BITS-1])) + ACC_W'(c1);
        j_acc  = ACC_W'($signed(pr2[2*COMP_W-1:FRAC_BITS-1])) + ACC_W'(cfg.const_j);
        k_acc  = ACC_W'($signed(pr3[2*COMP_W-1:FRAC_BITS-1])) + ACC_W'(cfg.const_k);

        z_iter.a = sat_comp(re_acc);
        z_iter.b = sat_comp(i_acc);
        z_iter.c = sat_comp(j_acc);
        z_iter.d = sat_comp(k_acc);

        z_next    = z;
        c0_next   = c0;
        c1_next   = c1;
        escaped   = 1'b0;
        magnitude = '0;

        unique case (op_t'(operation))
            OP_START:
            begin
                if (cfg.julia_mode)
                begin
                    z_next.a = pixel_re;
                    z_next.b = pixel_im;
                    z_next.c = cfg.start_j;
                    z_next.d = cfg.start_k;
                    c0_next  = cfg.const_real;
                    c1_next  = cfg.const_i;
                end
                else
                begin
                    z_next  = '0;
                    c0_next = pixel_re;
                    c1_next = pixel_im;
                end
            end
            OP_ITERATE:
            begin
                escaped = over_limit;
                if (!over_limit)
                    z_next = z_iter;
                if (mag_sum[SUM_W-1:MAG_W] != '0)
                    magnitude = '1;
                else
                    magnitude = mag_sum[MAG_W-1:0];
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/quaternion_fractal_orbit_step_core.sv
// Quaternion fractal orbit step core: one start or iterate transaction per cycle
// while the output is not stalled. A transaction is held in the input register,
// then passed to the result register; the orbit state register feeds the
// single-pass datapath of the next transaction directly.
// Reset: rst_n clears the orbit point and latched constant to zero, julia_mode
// to 1 and bailout_limit to 4.0; depends on qfo_pkg, qfo_cfg_regs, qfo_step_dp.
`default_nettype none

module quaternion_fractal_orbit_step_core
    import qfo_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]          cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 operation,
    input  wire comp_t                pixel_re,
    input  wire comp_t                pixel_im,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic                      escaped,
    output logic [MAG_W-1:0]          magnitude,
    output comp_t                     orbit_a,
    output comp_t                     orbit_b,
    output comp_t                     orbit_c,
    output comp_t                     orbit_d
);

    cfg_t             cfg;

    logic             in_valid_reg;
    logic             op_reg;
    comp_t            px_reg;
    comp_t            py_reg;

    quat_t            z_reg;
    comp_t            c0_reg;
    comp_t            c1_reg;
    quat_t            z_next;
    comp_t            c0_next;
    comp_t            c1_next;
    logic             escaped_next;
    logic [MAG_W-1:0] magnitude_next;

    logic             out_valid_reg;
    logic             escaped_reg;
    logic [MAG_W-1:0] magnitude_reg;
    quat_t            orbit_reg;

    logic             advance;
    logic             in_take;

    assign cfg_ready = 1'b1;

    qfo_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    qfo_step_dp u_step_dp (
        .operation (op_reg),
        .pixel_re  (px_reg),
        .pixel_im  (py_reg),
        .z         (z_reg),
        .c0        (c0_reg),
        .c1        (c1_reg),
        .cfg       (cfg),
        .z_next    (z_next),
        .c0_next   (c0_next),
        .c1_next   (c1_next),
        .escaped   (escaped_next),
        .magnitude (magnitude_next)
    );

    // A held transaction moves to the result register whenever that register frees up.
    assign advance  = in_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~in_valid_reg | advance;
    assign in_take  = in_valid & in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            z_reg         <= '0;
            c0_reg        <= '0;
            c1_reg        <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                z_reg         <= z_next;
                c0_reg        <= c0_next;
                c1_reg        <= c1_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg <= operation;
            px_reg <= pixel_re;
            py_reg <= pixel_im;
        end
        if (advance)
        begin
            escaped_reg   <= escaped_next;
            magnitude_reg <= magnitude_next;
            orbit_reg     <= z_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign escaped   = escaped_reg;
    assign magnitude = magnitude_reg;
    assign orbit_a   = orbit_reg.a;
    assign orbit_b   = orbit_reg.b;
    assign orbit_c   = orbit_reg.c;
    assign orbit_d   = orbit_reg.d;

endmodule

`default_nettype wire

// File: test/quaternion_fractal_orbit_step_core_test.sv
// Self-checking testbench for quaternion_fractal_orbit_step_core: a table of edge-case
// transactions, then randomized start/iterate bursts under varying register settings.
// Depends on qfo_pkg and the core RTL; results are checked against an orbit predictor.
module quaternion_fractal_orbit_step_core_test;
    import qfo_pkg::*;

    typedef struct packed {
        logic             escaped;
        logic [MAG_W-1:0] magnitude;
        comp_t            a;
        comp_t            b;
        comp_t            c;
        comp_t            d;
    } orbit_res_t;

    typedef struct packed {
        logic        is_cfg;
        reg_idx_t    reg_idx;
        logic [31:0] wdata;
        op_t         op;
        comp_t       px;
        comp_t       py;
        logic        typed;
        orbit_res_t  res;
    } stim_row_t;

    localparam int         CYCLE_LIMIT = 1_000_000;
    localparam orbit_res_t NO_ORBIT    = '0;

    localparam stim_row_t EDGE_CASE_ROWS [32] = '{
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b1, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1,
          '{1'b0, 32'h0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0}},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, 32'sh0}},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'sh2000_0000, 32'sh0, 1'b1,
          '{1'b0, 32'h0, 32'sh2000_0000, 32'sh0, 32'sh0, 32'sh0}},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b1,
          '{1'b0, 32'h4000_0000, 32'sh4000_0000, 32'sh0, 32'sh0, 32'sh0}},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b1,
          '{1'b1, 32'hFFFF_FFFF, 32'sh4000_0000, 32'sh0, 32'sh0, 32'sh0}},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'shFFFF_FFFF, 32'sh1, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_BAILOUT_LIMIT, 32'hFFFF_FFFF, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_CONST_REAL, 32'h7FFF_FFFF, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_CONST_I, 32'h8000_0000, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'sh3FFF_FFFF, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_CONST_REAL, 32'h8000_0000, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'sh0, 32'sh3FFF_FFFF, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'sh2D41_3CCC, 32'sh2D41_3CCC, 1'b0,
          NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_START_J, 32'h7FFF_FFFF, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_START_K, 32'h8000_0000, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_CONST_J, 32'h8000_0000, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_CONST_K, 32'h7FFF_FFFF, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_START_J, 32'h0, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_START_K, 32'h0, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_JULIA_MODE, 32'hFFFF_FFFE, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_START, 32'shF000_0000, 32'sh0800_0000, 1'b1,
          NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b0, REG_JULIA_MODE, 32'h0, OP_ITERATE, 32'sh0, 32'sh0, 1'b0, NO_ORBIT},
        '{1'b1, REG_BAILOUT_LIMIT, 32'h4000_0000, OP_START, 32'sh0, 32'sh0, 1'b0, NO_ORBIT}
    };

    logic             clk;
    logic             rst_n;
    logic             cfg_valid;
    logic             cfg_ready;
    reg_idx_t         cfg_index;
    logic [31:0]      cfg_data;
    logic             in_valid;
    logic             in_ready;
    op_t              operation;
    comp_t            pixel_re;
    comp_t            pixel_im;
    logic             out_valid;
    logic             out_ready;
    logic             escaped;
    logic [MAG_W-1:0] magnitude;
    comp_t            orbit_a;
    comp_t            orbit_b;
    comp_t            orbit_c;
    comp_t            orbit_d;

    logic       row_typed;
    orbit_res_t row_res;

    cfg_t  model_cfg;
    comp_t orbit_z [4];
    comp_t latched_c0;
    comp_t latched_c1;

    orbit_res_t expected_orbits [$];
    int         idle_pct;
    int         stall_left;
    int         cycle_count;
    int         mismatches;
    int         starts_seen;
    int         iterations_seen;
    int         escapes_seen;
    int         writes_seen;

    quaternion_fractal_orbit_step_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .pixel_re  (pixel_re),
        .pixel_im  (pixel_im),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .escaped   (escaped),
        .magnitude (magnitude),
        .orbit_a   (orbit_a),
        .orbit_b   (orbit_b),
        .orbit_c   (orbit_c),
        .orbit_d   (orbit_d)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint square_q28(comp_t x);
        longint s;
        s = x;
        return (s * s) >>> FRAC_BITS;
    endfunction

    function automatic comp_t clamp_comp(longint v);
        if (v > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (v < longint'(32'sh8000_0000))
            return 32'sh8000_0000;
        return comp_t'(v);
    endfunction

    function automatic void reset_orbit_model();
        model_cfg = '0;
        model_cfg.julia_mode = 1'b1;
        model_cfg.bailout_limit = BAILOUT_RESET;
        foreach (orbit_z[i])
            orbit_z[i] = '0;
        latched_c0 = '0;
        latched_c1 = '0;
    endfunction

    function automatic void apply_register(reg_idx_t idx, logic [31:0] v);
        case (idx)
            REG_JULIA_MODE:    model_cfg.julia_mode = v[0];
            REG_CONST_REAL:    model_cfg.const_real = v;
            REG_CONST_I:       model_cfg.const_i = v;
            REG_CONST_J:       model_cfg.const_j = v;
            REG_CONST_K:       model_cfg.const_k = v;
            REG_START_J:       model_cfg.start_j = v;
            REG_START_K:       model_cfg.start_k = v;
            REG_BAILOUT_LIMIT: model_cfg.bailout_limit = v;
            default: ;
        endcase
    endfunction

    function automatic orbit_res_t step_orbit(op_t op, comp_t px, comp_t py);
        orbit_res_t r;
        longint     sq [4];
        longint     total;
        longint     a0;
        longint     prod;
        comp_t      cterm [4];
        comp_t      nz [4];
        r = '0;
        if (op == OP_START) begin
            if (model_cfg.julia_mode) begin
                orbit_z[0] = px;
                orbit_z[1] = py;
                orbit_z[2] = model_cfg.start_j;
                orbit_z[3] = model_cfg.start_k;
                latched_c0 = model_cfg.const_real;
                latched_c1 = model_cfg.const_i;
            end
            else begin
                foreach (orbit_z[i])
                    orbit_z[i] = '0;
                latched_c0 = px;
                latched_c1 = py;
            end
        end
        else begin
            total = 0;
            for (int i = 0; i < 4; i++) begin
                sq[i] = square_q28(orbit_z[i]);
                total += sq[i];
            end
            if (total > longint'({32'h0, model_cfg.bailout_limit})) begin
                r.escaped = 1'b1;
            end
            else begin
                cterm[0] = latched_c0;
                cterm[1] = latched_c1;
                cterm[2] = model_cfg.const_j;
                cterm[3] = model_cfg.const_k;
                a0 = orbit_z[0];
                nz[0] = clamp_comp(sq[0] - sq[1] - sq[2] - sq[3] + longint'(cterm[0]));
                for (int i = 1; i < 4; i++) begin
                    prod = a0 * longint'(orbit_z[i]);
                    nz[i] = clamp_comp((prod >>> (FRAC_BITS - 1)) + longint'(cterm[i]));
                end
                orbit_z = nz;
            end
            r.magnitude = (total > 64'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
        end
        r.a = orbit_z[0];
        r.b = orbit_z[1];
        r.c = orbit_z[2];
        r.d = orbit_z[3];
        return r;
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s: expected %h, got %h", field, want, got);
        end
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(99) >= idle_pct)
            return 0;
        if ($urandom_range(9) == 0)
            return $urandom_range(40, 10);
        return $urandom_range(3, 1);
    endfunction

    function automatic comp_t pick_coord();
        comp_t v;
        case ($urandom_range(15))
            0: v = $urandom;
            1: v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default:
            begin
                v = $urandom_range(32'h4000_0000);
                v = v - 32'sh2000_0000;
            end
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_bailout(int phase);
        if (phase == 1)
            return 32'h0;
        if (phase == 2)
            return 32'hFFFF_FFFF;
        case ($urandom_range(3))
            0: return BAILOUT_RESET;
            1: return $urandom;
            2: return $urandom_range(32'h8000_0000, 32'h1000_0000);
            default: return $urandom_range(32'h4000_0000, 32'h1000_0000);
        endcase
    endfunction

    // Stimulus tasks are called and return on a falling edge.
    task automatic send_item(op_t op, comp_t px, comp_t py, logic typed, orbit_res_t res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        operation = op;
        pixel_re = px;
        pixel_im = py;
        row_typed = typed;
        row_res = res;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic drain_stream();
        in_valid = 1'b0;
        while (expected_orbits.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(reg_idx_t idx, logic [31:0] value);
        cfg_index = idx;
        cfg_data = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    initial
    begin
        out_ready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                out_ready = 1'b0;
                stall_left--;
            end
            else begin
                out_ready = 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_orbits.size());
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        orbit_res_t want;
        orbit_res_t got;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                apply_register(cfg_index, cfg_data);
                writes_seen++;
            end
            if (in_valid && in_ready) begin
                want = step_orbit(operation, pixel_re, pixel_im);
                expected_orbits.push_back(row_typed ? row_res : want);
                if (operation == OP_START)
                    starts_seen++;
                else
                    iterations_seen++;
            end
            if (out_valid && out_ready) begin
                got = '{escaped, magnitude, orbit_a, orbit_b, orbit_c, orbit_d};
                if (escaped)
                    escapes_seen++;
                if (expected_orbits.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected result transaction: %h", got);
                end
                else begin
                    want = expected_orbits.pop_front();
                    check_field("escaped", 32'(want.escaped), 32'(got.escaped));
                    check_field("magnitude", want.magnitude, got.magnitude);
                    check_field("orbit_a", want.a, got.a);
                    check_field("orbit_b", want.b, got.b);
                    check_field("orbit_c", want.c, got.c);
                    check_field("orbit_d", want.d, got.d);
                end
            end
        end
    end

    initial
    begin
        int          sent;
        int          burst;
        logic [31:0] mode_word;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_JULIA_MODE;
        cfg_data = '0;
        in_valid = 1'b0;
        operation = OP_START;
        pixel_re = '0;
        pixel_im = '0;
        row_typed = 1'b0;
        row_res = NO_ORBIT;
        idle_pct = 25;
        cycle_count = 0;
        mismatches = 0;
        starts_seen = 0;
        iterations_seen = 0;
        escapes_seen = 0;
        writes_seen = 0;
        reset_orbit_model();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (EDGE_CASE_ROWS[i]) begin
            if (EDGE_CASE_ROWS[i].is_cfg) begin
                drain_stream();
                write_register(EDGE_CASE_ROWS[i].reg_idx, EDGE_CASE_ROWS[i].wdata);
            end
            else begin
                send_item(EDGE_CASE_ROWS[i].op, EDGE_CASE_ROWS[i].px, EDGE_CASE_ROWS[i].py,
                          EDGE_CASE_ROWS[i].typed, EDGE_CASE_ROWS[i].res);
            end
        end

        for (int phase = 0; phase < 16; phase++) begin
            drain_stream();
            idle_pct = (phase % 4 == 0) ? 0 : ((phase % 4 == 3) ? 60 : 25);
            mode_word = $urandom;
            mode_word[0] = $urandom_range(1);
            write_register(REG_JULIA_MODE, mode_word);
            if (phase == 0 || $urandom_range(1))
                write_register(REG_CONST_REAL, pick_coord());
            if (phase == 0 || $urandom_range(1))
                write_register(REG_CONST_I, pick_coord());
            if (phase == 0 || $urandom_range(1))
                write_register(REG_CONST_J, pick_coord());
            if (phase == 0 || $urandom_range(1))
                write_register(REG_CONST_K, pick_coord());
            if (phase == 0 || $urandom_range(1))
                write_register(REG_START_J, pick_coord());
            if (phase == 0 || $urandom_range(1))
                write_register(REG_START_K, pick_coord());
            write_register(REG_BAILOUT_LIMIT, pick_bailout(phase));

            // Carry on the previous orbit so the new live constants take effect.
            repeat ($urandom_range(3))
                send_item(OP_ITERATE, $urandom, $urandom, 1'b0, NO_ORBIT);

            sent = 0;
            while (sent < 125) begin
                if ($urandom_range(6) != 0) begin
                    burst = $urandom_range(24, 1);
                    send_item(OP_START, pick_coord(), pick_coord(), 1'b0, NO_ORBIT);
                    repeat (burst)
                        send_item(OP_ITERATE, $urandom, $urandom, 1'b0, NO_ORBIT);
                    sent += burst + 1;
                end
                else begin
                    send_item(op_t'($urandom_range(1)), $urandom, $urandom, 1'b0, NO_ORBIT);
                    sent++;
                end
            end
        end

        drain_stream();
        repeat (8) @(posedge clk);
        $display("Covered %0d transactions: %0d starts, %0d iterations, %0d escapes.",
                 starts_seen + iterations_seen, starts_seen, iterations_seen, escapes_seen);
        $display("Made %0d register writes across Julia and Mandelbrot settings; %0d mismatches.",
                 writes_seen, mismatches);
        if (mismatches == 0 && expected_orbits.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
